// ===== rtl/atlp_pkg.sv =====
`default_nettype none

package atlp_pkg;

    // Line buffer limit; only LINE_MAX-1 characters of a line are counted
    localparam int LINE_MAX = 64;
    localparam int CNT_W    = $clog2(LINE_MAX);
    localparam int VAL_W    = 15;
    localparam int LEN_W    = 6;
    localparam int CFG_W    = 15;

    // Prefix lengths
    localparam int TRASH_LEN = 6;
    localparam int HB_LEN    = 2;
    localparam int ACK_LEN   = 3;

    // Characters of interest
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Reset value of both coordinate limits
    localparam logic [CFG_W-1:0] MAX_RESET = 15'd639;

    // Configuration register indexes
    typedef enum logic {
        CFG_MAX_X = 1'b0,
        CFG_MAX_Y = 1'b1
    } cfg_idx_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TARGET    = 2'd0,
        KIND_HEARTBEAT = 2'd1,
        KIND_ACK       = 2'd2
    } kind_t;

    // Coordinate parser phase
    typedef enum logic [2:0] {
        PH_X_START = 3'd0,
        PH_X_DIGIT = 3'd1,
        PH_Y_START = 3'd2,
        PH_Y_DIGIT = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    // One result request
    typedef struct packed {
        kind_t             kind;
        logic [VAL_W-1:0]  x;
        logic [VAL_W-1:0]  y;
        logic [LEN_W-1:0]  len;
    } result_t;

    function automatic logic [7:0] trash_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h54; // T
            3'd1:    ch = 8'h52; // R
            3'd2:    ch = 8'h41; // A
            3'd3:    ch = 8'h53; // S
            3'd4:    ch = 8'h48; // H
            3'd5:    ch = 8'h2C; // ,
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] hb_char(input logic idx);
        return idx ? 8'h42 : 8'h48; // H B
    endfunction

    function automatic logic [7:0] ack_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h41; // A
            2'd1:    ch = 8'h43; // C
            2'd2:    ch = 8'h4B; // K
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // acc*10 + d, saturated at 32767; msb flags the saturation
    function automatic logic [VAL_W:0] add_digit(input logic [VAL_W-1:0] acc,
                                                 input logic [3:0] d);
        logic [VAL_W+3:0] v;
        logic             ovf;
        v   = {acc, 3'b000} + {3'b000, acc, 1'b0} + {{VAL_W{1'b0}}, d};
        ovf = |v[VAL_W+3:VAL_W];
        return {ovf, ovf ? {VAL_W{1'b1}} : v[VAL_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ascii_target_line_parser_top.sv =====
// ASCII target line parser.
// Input channel: one received character per request on rx_byte, qualified by
// in_valid, accepted when in_valid is high and in_stall is low. CR or LF ends
// a line; lines starting "TRASH," give a target (x, y) if both lie within
// max_x / max_y, "HB" gives a heartbeat, "ACK" an acknowledge.
// Output channel: packet_kind, target_x, target_y, line_length, qualified by
// out_valid, taken when out_stall is low. At most one result per line.
// The result of a line terminator is registered into the output buffer as
// the terminator is accepted. Throughput: one character per cycle while
// in_stall is low, set by the line state update (one multiply-by-ten add).
// Configuration: cfg_write with cfg_index / cfg_data sets max_x (index 0)
// or max_y (index 1) at the clock edge.
// Stall: results go into a two-entry output buffer; in_stall rises only when
// both entries are full, so characters keep flowing while one result waits.
// Reset clears the line state, empties the output buffer and sets both
// limits to 639.
`default_nettype none

module ascii_target_line_parser_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         packet_kind,
    output logic [atlp_pkg::VAL_W-1:0]         target_x,
    output logic [atlp_pkg::VAL_W-1:0]         target_y,
    output logic [atlp_pkg::LEN_W-1:0]         line_length,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [atlp_pkg::CFG_W-1:0]    cfg_data
);
    import atlp_pkg::*;

    // Configuration
    logic [CFG_W-1:0] max_x_reg, max_y_reg;

    // Line state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0]       alive_reg, alive_next;
    phase_t           phase_reg, phase_next;
    logic [1:0]       sign_reg, sign_next;
    logic [VAL_W-1:0] x_reg, x_next;
    logic [VAL_W-1:0] y_reg, y_next;
    logic [1:0]       ovf_reg, ovf_next;

    // Output buffer
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;

    logic             accept, eol, is_digit, is_minus, is_comma, counting;
    logic [3:0]       digit;
    logic [VAL_W:0]   x_add, y_add;
    logic             res_valid;
    result_t          res;
    logic             coords_ok;
    logic             pop, push;

    assign accept   = in_valid && !in_stall;
    assign eol      = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_minus = (rx_byte == CH_MINUS);
    assign is_comma = (rx_byte == CH_COMMA);
    assign digit    = 4'(rx_byte - CH_ZERO);
    assign counting = count_reg < CNT_W'(LINE_MAX - 1);
    assign x_add    = add_digit(x_reg, digit);
    assign y_add    = add_digit(y_reg, digit);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MAX_RESET;
            max_y_reg <= MAX_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_X: max_x_reg <= cfg_data;
                CFG_MAX_Y: max_y_reg <= cfg_data;
                default:   max_x_reg <= max_x_reg;
            endcase
        end
    end

    // Next line state
    always_comb
    begin
        count_next = count_reg;
        alive_next = alive_reg;
        phase_next = phase_reg;
        sign_next  = sign_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ovf_next   = ovf_reg;

        if (accept && eol)
        begin
            count_next = '0;
            alive_next = 3'b111;
            phase_next = PH_X_START;
            sign_next  = '0;
            x_next     = '0;
            y_next     = '0;
            ovf_next   = '0;
        end
        else if (accept && counting)
        begin
            count_next = count_reg + 1'b1;

            // prefix tracking
            if (count_reg < CNT_W'(TRASH_LEN))
            begin
                if (rx_byte != trash_char(count_reg[2:0]))
                    alive_next[0] = 1'b0;
            end
            if (count_reg < CNT_W'(HB_LEN) && rx_byte != hb_char(count_reg[0]))
                alive_next[1] = 1'b0;
            if (count_reg < CNT_W'(ACK_LEN) && rx_byte != ack_char(count_reg[1:0]))
                alive_next[2] = 1'b0;

            // coordinate parsing after the prefix
            if (count_reg >= CNT_W'(TRASH_LEN))
            begin
                unique case (phase_reg)
                    PH_X_START, PH_X_DIGIT:
                    begin
                        priority if (phase_reg == PH_X_START && is_minus)
                        begin
                            sign_next[0] = 1'b1;
                            phase_next   = PH_X_DIGIT;
                        end
                        else if (is_digit)
                        begin
                            x_next      = x_add[VAL_W-1:0];
                            ovf_next[0] = ovf_reg[0] | x_add[VAL_W];
                            phase_next  = PH_X_DIGIT;
                        end
                        else if (is_comma)
                            phase_next = PH_Y_START;
                        else if (is_minus)
                        begin
                            sign_next[1] = 1'b1;
                            phase_next   = PH_Y_DIGIT;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    PH_Y_START, PH_Y_DIGIT:
                    begin
                        priority if (phase_reg == PH_Y_START && is_minus)
                        begin
                            sign_next[1] = 1'b1;
                            phase_next   = PH_Y_DIGIT;
                        end
                        else if (is_digit)
                        begin
                            y_next      = y_add[VAL_W-1:0];
                            ovf_next[1] = ovf_reg[1] | y_add[VAL_W];
                            phase_next  = PH_Y_DIGIT;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    default: phase_next = PH_DONE;
                endcase
            end
        end
    end

    // Line classification at the terminator
    always_comb
    begin
        coords_ok = (ovf_reg == 2'b00)
                 && (!sign_reg[0] || x_reg == '0)
                 && (!sign_reg[1] || y_reg == '0)
                 && (x_reg <= max_x_reg) && (y_reg <= max_y_reg);
        res_valid = 1'b0;
        res.kind  = KIND_TARGET;
        res.x     = '0;
        res.y     = '0;
        res.len   = LEN_W'(count_reg);

        if (accept && eol && count_reg != '0)
        begin
            priority if (alive_reg[0] && count_reg >= CNT_W'(TRASH_LEN))
            begin
                res_valid = coords_ok;
                res.x     = x_reg;
                res.y     = y_reg;
            end
            else if (alive_reg[1] && count_reg >= CNT_W'(HB_LEN))
            begin
                res_valid = 1'b1;
                res.kind  = KIND_HEARTBEAT;
            end
            else if (alive_reg[2] && count_reg >= CNT_W'(ACK_LEN))
            begin
                res_valid = 1'b1;
                res.kind  = KIND_ACK;
            end
            else
                res_valid = 1'b0;
        end
    end

    // Two-entry output buffer
    assign pop  = out_valid_reg && !out_stall;
    assign push = res_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            alive_reg      <= 3'b111;
            phase_reg      <= PH_X_START;
            sign_reg       <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            ovf_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            alive_reg      <= alive_next;
            phase_reg      <= phase_next;
            sign_reg       <= sign_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_stall    = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign packet_kind = out_reg.kind;
    assign target_x    = out_reg.x;
    assign target_y    = out_reg.y;
    assign line_length = out_reg.len;

endmodule

`default_nettype wire

// ===== rtl/atlp_checker.sv =====
`default_nettype none

module atlp_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [1:0]                    packet_kind,
    input wire logic [atlp_pkg::VAL_W-1:0]    target_x,
    input wire logic [atlp_pkg::VAL_W-1:0]    target_y,
    input wire logic [atlp_pkg::LEN_W-1:0]    line_length
);
    import atlp_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(packet_kind) && $stable(target_x)
            && $stable(target_y) && $stable(line_length))
        else $error("stalled result changed");

    // Only the three defined kinds appear
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> packet_kind == KIND_TARGET || packet_kind == KIND_HEARTBEAT
            || packet_kind == KIND_ACK)
        else $error("undefined result kind");

    // Coordinates are zero on non-target results
    a_coord_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_kind != KIND_TARGET |-> target_x == '0 && target_y == '0)
        else $error("coordinates on a non-target result");

    // A target line holds at least the full prefix
    a_target_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_kind == KIND_TARGET |-> line_length >= LEN_W'(TRASH_LEN))
        else $error("target from a short line");

endmodule

bind ascii_target_line_parser_top atlp_checker u_atlp_checker (.*);

`default_nettype wire

// ===== tb/ascii_target_line_parser_top_test.sv =====
`timescale 1ns / 100ps

module ascii_target_line_parser_top_test;

    import atlp_pkg::*;

    // Cycles without any accepted request before the run is declared hung
    localparam int STUCK_LIMIT = 5000;

    // Prefix words, first character in the top byte
    localparam logic [8*TRASH_LEN-1:0] TRASH_WORD = "TRASH,";
    localparam logic [8*HB_LEN-1:0]    HB_WORD    = "HB";
    localparam logic [8*ACK_LEN-1:0]   ACK_WORD   = "ACK";

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte     = 8'h00;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [1:0]         packet_kind;
    logic [VAL_W-1:0]   target_x;
    logic [VAL_W-1:0]   target_y;
    logic [LEN_W-1:0]   line_length;
    logic               cfg_write   = 1'b0;
    logic               cfg_index   = 1'b0;
    logic [CFG_W-1:0]   cfg_data    = '0;

    // Idle rates in percent and the receiver hold-off
    int unsigned        send_idle_pct = 33;
    int unsigned        recv_idle_pct = 87;
    int unsigned        hold_off_left = 0;

    // Line state of the predictor and its copy of the limits
    int unsigned        line_len;
    logic               trash_ok;
    logic               hb_ok;
    logic               ack_ok;
    phase_t             coord_phase;
    logic               neg_x;
    logic               neg_y;
    logic               ovf_x;
    logic               ovf_y;
    logic [VAL_W-1:0]   acc_x;
    logic [VAL_W-1:0]   acc_y;
    logic [CFG_W-1:0]   lim_x;
    logic [CFG_W-1:0]   lim_y;

    result_t            expected_packets[$];

    // Statistics
    int unsigned        errors             = 0;
    int unsigned        chars_sent         = 0;
    int unsigned        lines_closed       = 0;
    int unsigned        input_stall_cycles = 0;
    int unsigned        n_targets          = 0;
    int unsigned        n_heartbeats       = 0;
    int unsigned        n_acks             = 0;

    ascii_target_line_parser_top DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packet_kind (packet_kind),
        .target_x    (target_x),
        .target_y    (target_y),
        .line_length (line_length),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------

    function automatic void start_new_line();
        line_len    = 0;
        trash_ok    = 1'b1;
        hb_ok       = 1'b1;
        ack_ok      = 1'b1;
        coord_phase = PH_X_START;
        neg_x       = 1'b0;
        neg_y       = 1'b0;
        ovf_x       = 1'b0;
        ovf_y       = 1'b0;
        acc_x       = '0;
        acc_y       = '0;
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    // acc*10 + digit, clamped to 32767; top bit marks the clamp
    function automatic logic [VAL_W:0] append_digit(input logic [VAL_W-1:0] acc,
                                                    input logic [7:0] ch);
        int v;
        v = int'(acc) * 10 + int'(ch) - int'(CH_ZERO);
        if (v > 32767)
            return {1'b1, {VAL_W{1'b1}}};
        return {1'b0, v[VAL_W-1:0]};
    endfunction

    // y part: a leading '-' only as the first character
    function automatic void scan_y(input logic [7:0] ch, input bit first);
        logic [VAL_W:0] sum;
        if (is_digit(ch))
        begin
            sum         = append_digit(acc_y, ch);
            ovf_y       = ovf_y | sum[VAL_W];
            acc_y       = sum[VAL_W-1:0];
            coord_phase = PH_Y_DIGIT;
        end
        else if (first && ch == CH_MINUS)
        begin
            neg_y       = 1'b1;
            coord_phase = PH_Y_DIGIT;
        end
        else
            coord_phase = PH_DONE;
    endfunction

    function automatic void scan_coord(input logic [7:0] ch);
        logic [VAL_W:0] sum;
        case (coord_phase)
            PH_X_START, PH_X_DIGIT:
            begin
                if (is_digit(ch))
                begin
                    sum         = append_digit(acc_x, ch);
                    ovf_x       = ovf_x | sum[VAL_W];
                    acc_x       = sum[VAL_W-1:0];
                    coord_phase = PH_X_DIGIT;
                end
                else if (coord_phase == PH_X_START && ch == CH_MINUS)
                begin
                    neg_x       = 1'b1;
                    coord_phase = PH_X_DIGIT;
                end
                else if (ch == CH_COMMA)
                    coord_phase = PH_Y_START;
                else
                    scan_y(ch, 1'b1); // no comma: this character already opens y
            end
            PH_Y_START: scan_y(ch, 1'b1);
            PH_Y_DIGIT: scan_y(ch, 1'b0);
            default: ;
        endcase
    endfunction

    // Advance the line state by one accepted character; queue any result
    function automatic void track_line(input logic [7:0] ch);
        result_t     pkt;
        bit          found;
        int unsigned pos;
        pos = line_len;
        if (ch == CH_LF || ch == CH_CR)
        begin
            if (line_len != 0)
            begin
                pkt   = '0;
                found = 1'b0;
                lines_closed++;
                if (trash_ok && line_len >= TRASH_LEN)
                begin
                    // any flaw in a coordinate line drops it without a result
                    if (!ovf_x && !ovf_y && (!neg_x || acc_x == 0) &&
                        (!neg_y || acc_y == 0) && acc_x <= lim_x && acc_y <= lim_y)
                    begin
                        pkt.kind = KIND_TARGET;
                        pkt.x    = acc_x;
                        pkt.y    = acc_y;
                        found    = 1'b1;
                    end
                end
                else if (hb_ok && line_len >= HB_LEN)
                begin
                    pkt.kind = KIND_HEARTBEAT;
                    found    = 1'b1;
                end
                else if (ack_ok && line_len >= ACK_LEN)
                begin
                    pkt.kind = KIND_ACK;
                    found    = 1'b1;
                end
                if (found)
                begin
                    pkt.len = line_len[LEN_W-1:0];
                    expected_packets.push_back(pkt);
                end
            end
            start_new_line();
        end
        else if (line_len < LINE_MAX - 1)
        begin
            if (pos < TRASH_LEN)
            begin
                if (ch != TRASH_WORD[8*(TRASH_LEN-1-pos) +: 8])
                    trash_ok = 1'b0;
            end
            else
                scan_coord(ch);
            if (pos < HB_LEN && ch != HB_WORD[8*(HB_LEN-1-pos) +: 8])
                hb_ok = 1'b0;
            if (pos < ACK_LEN && ch != ACK_WORD[8*(ACK_LEN-1-pos) +: 8])
                ack_ok = 1'b0;
            line_len++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random stall, or a counted hold-off
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_stall = 1'b1;
            hold_off_left--;
        end
        else
            out_stall = ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted result with the oldest queued one
    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_packets.size() == 0)
            begin
                $error("unexpected result: packet_kind %0d target_x %0d target_y %0d len %0d",
                       packet_kind, target_x, target_y, line_length);
                errors++;
            end
            else
            begin
                want = expected_packets.pop_front();
                if (packet_kind !== want.kind)
                begin
                    $error("packet_kind: expected %0d, got %0d", want.kind, packet_kind);
                    errors++;
                end
                if (target_x !== want.x)
                begin
                    $error("target_x: expected %0d, got %0d", want.x, target_x);
                    errors++;
                end
                if (target_y !== want.y)
                begin
                    $error("target_y: expected %0d, got %0d", want.y, target_y);
                    errors++;
                end
                if (line_length !== want.len)
                begin
                    $error("line_length: expected %0d, got %0d", want.len, line_length);
                    errors++;
                end
                case (want.kind)
                    KIND_TARGET:    n_targets++;
                    KIND_HEARTBEAT: n_heartbeats++;
                    default:        n_acks++;
                endcase
            end
        end
    end

    // Hang detection: count cycles in which no request of any kind moves
    initial
    begin : watchdog
        int unsigned stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                stuck = 0;
            else
                stuck++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender helpers; all start and end just after a falling edge
    // ------------------------------------------------------------------

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [7:0] random_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CH_LF || b == CH_CR)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // Zero, the limit, just over it, large or saturating values, or any value up to the limit
    function automatic int unsigned pick_value(input int unsigned limit);
        int unsigned value;
        case ($urandom_range(6))
            0:       value = 0;
            1:       value = limit;
            2:       value = limit + 1;
            3:       value = $urandom_range(99999);
            4:       value = $urandom_range(40000, 32000);
            default: value = $urandom_range(limit);
        endcase
        return value;
    endfunction

    // Leading zeros; a few runs are long enough to cross the line limit
    function automatic int unsigned pick_pad();
        if (chance(10))
            return $urandom_range(3, 1);
        if (chance(2))
            return $urandom_range(60, 45);
        return 0;
    endfunction

    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            rx_byte  = 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = ch;
        @(posedge clk);
        while (in_stall)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        track_line(ch);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i]);
    endtask

    task automatic send_junk(input int unsigned count);
        repeat (count)
            send_char(random_text_byte());
    endtask

    task automatic send_number(input int unsigned value, input int unsigned pad);
        logic [7:0]  digits[$];
        int unsigned v;
        v = value;
        do
        begin
            digits.push_front(8'(int'(CH_ZERO) + v % 10));
            v = v / 10;
        end
        while (v != 0);
        repeat (pad)
            send_char(CH_ZERO);
        foreach (digits[i])
            send_char(digits[i]);
    endtask

    task automatic end_line();
        case ($urandom_range(2))
            0: send_char(CH_LF);
            1: send_char(CH_CR);
            default:
            begin
                send_char(CH_CR);
                send_char(CH_LF);
            end
        endcase
    endtask

    task automatic send_line(input string text);
        send_text(text);
        end_line();
    endtask

    // Lower valid, let every queued result drain, then a few spare cycles
    task automatic wait_for_results();
        in_valid = 1'b0;
        while (expected_packets.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_limit(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_MAX_X)
            lim_x = value;
        else
            lim_y = value;
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y);
        wait_for_results();
        write_limit(CFG_MAX_X, x);
        write_limit(CFG_MAX_Y, y);
    endtask

    // Coordinate line with random signs, separators, padding and tail
    task automatic send_target_text();
        send_text("TRASH,");
        if (chance(15))
            send_char(CH_MINUS);
        if (!chance(8))
            send_number(pick_value(lim_x), pick_pad());
        case ($urandom_range(9))
            0: ;
            1: send_char(random_text_byte());
            default: send_char(CH_COMMA);
        endcase
        if (chance(15))
            send_char(CH_MINUS);
        if (!chance(8))
            send_number(pick_value(lim_y), pick_pad());
        if (chance(25))
            send_junk($urandom_range(6, 1));
    endtask

    task automatic send_random_line();
        int unsigned pick;
        int unsigned cut;
        string       word;
        pick = $urandom_range(99);
        if (pick < 50)
            send_target_text();
        else if (pick < 60)
        begin
            send_text("HB");
            send_junk($urandom_range(8));
        end
        else if (pick < 70)
        begin
            send_text("ACK");
            send_junk($urandom_range(8));
        end
        else if (pick < 80)
        begin
            // prefix cut short or with one character replaced
            case ($urandom_range(2))
                0:       word = "TRASH,";
                1:       word = "HB";
                default: word = "ACK";
            endcase
            cut = $urandom_range(word.len() - 1);
            if (chance(50))
            begin
                for (int i = 0; i < cut; i++)
                    send_char(word[i]);
            end
            else
            begin
                for (int i = 0; i < word.len(); i++)
                    send_char((i == cut) ? random_text_byte() : word[i]);
            end
            send_junk($urandom_range(6));
        end
        else if (pick < 90)
            send_junk($urandom_range(20));
        else if (pick >= 95)
        begin
            // overlong line
            if (chance(50))
                send_text("HB");
            else
                send_text("TRASH,1,2");
            send_junk($urandom_range(80, 55));
        end
        end_line();
    endtask

    task automatic run_random_lines(input int unsigned count);
        int unsigned stop_at;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at)
            send_random_line();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every line kind and the corner cases, at the reset limits
    task automatic test_directed_lines();
        send_line("HB");
        send_line("ACK");
        send_line("TRASH,0,0");
        send_line("TRASH,639,639");
        send_line("TRASH,640,1");
        send_line("TRASH,-0,-0");
        send_line("TRASH,-3,4");
        send_line("TRASH,99999,1");
        send_line("TRASH,5-0");
        send_line("TRASH");
        send_line("AC");
        send_line("H");
        // empty line
        send_char(CH_CR);
        send_char(CH_LF);
        // NUL right after the prefix ends both numbers at zero
        send_text("TRASH,");
        send_char(8'h00);
        end_line();
        send_char(8'h00);
        send_line("HB");
        // overlong lines: the tail is dropped, length stops at 63
        send_text("ACK");
        repeat (70)
            send_char(8'hFF);
        end_line();
        send_text("TRASH,1,");
        repeat (60)
            send_char(CH_ZERO);
        send_line("7");
    endtask

    task automatic test_limit_extremes();
        set_limits('0, '0);
        send_line("TRASH,0,0");
        send_line("TRASH,1,0");
        run_random_lines(80);
        set_limits('1, '1);
        send_line("TRASH,32767,32767");
        send_line("TRASH,32768,0");
        run_random_lines(80);
        set_limits('0, '1);
        run_random_lines(80);
        set_limits('1, '0);
        run_random_lines(80);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        logic [CFG_W-1:0] x;
        logic [CFG_W-1:0] y;
        x = chance(50) ? CFG_W'($urandom_range(1000)) : CFG_W'($urandom_range(32767));
        y = chance(50) ? CFG_W'($urandom_range(1000)) : CFG_W'($urandom_range(32767));
        set_limits(x, y);
        run_random_lines(count);
    endtask

    // Long receiver hold-off so the output buffer fills and input stalls
    task automatic test_backpressure();
        hold_off_left = 300;
        repeat (30)
        begin
            if (chance(50))
                send_text("HB");
            else
                send_text("ACK");
            end_line();
        end
        wait_for_results();
    endtask

    initial
    begin
        start_new_line();
        lim_x = MAX_RESET;
        lim_y = MAX_RESET;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles rarely, receiver often
        send_idle_pct = 33;
        recv_idle_pct = 87;
        test_directed_lines();
        test_limit_extremes();
        test_random_traffic(250);

        // and the other way round
        send_idle_pct = 87;
        recv_idle_pct = 33;
        test_random_traffic(250);
        test_backpressure();

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(250);

        wait_for_results();
        repeat (16)
            @(negedge clk);

        $display("covered %0d characters in %0d lines, %0d cycles of input stall",
                 chars_sent, lines_closed, input_stall_cycles);
        $display("checked %0d targets, %0d heartbeats, %0d acknowledges, %0d mismatches",
                 n_targets, n_heartbeats, n_acks, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
